FILE: hdl/pur_pkg.sv
// ----------------------------------------------------------------------------
// pur_pkg: shared types and constants for the picture-unit register port
// Holds the access opcodes, register numbers, video bus map constants and the
// small types that pass between the register logic and its memories.
// ----------------------------------------------------------------------------
package pur_pkg;

    // Access opcodes carried by an input item.
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_STATUS = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // CPU-visible register numbers.
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SPADDR = 3'd3;
    localparam logic [2:0] REG_SPDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    // Mirroring modes of the configuration register.
    localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;

    // Fixed memory sizes.
    localparam int SPRITE_BYTES    = 256;
    localparam int PALETTE_ENTRIES = 32;
    localparam int PATTERN_BYTES   = 8192;
    localparam int SPRITE_AW       = $clog2(SPRITE_BYTES);
    localparam int PALETTE_AW      = $clog2(PALETTE_ENTRIES);
    localparam int PATTERN_AW      = $clog2(PATTERN_BYTES);

    // Nametable offsets after mirroring always fit in eleven bits.
    localparam int NT_IDX_W = 11;

    // Upper six bits of a palette address on the 14-bit video bus.
    localparam logic [5:0] PALETTE_PAGE = 6'h3F;

    // Which video memory the latest data-port read went to.
    typedef enum logic [1:0] {
        SRC_PATTERN   = 2'd0,
        SRC_NAMETABLE = 2'd1,
        SRC_PALETTE   = 2'd2,
        SRC_ZERO      = 2'd3
    } bus_src_t;

    // Where the read byte of an item in flight comes from.
    typedef enum logic [1:0] {
        RD_VALUE  = 2'd0,
        RD_SPRITE = 2'd1,
        RD_BUS    = 2'd2,
        RD_SPARE  = 2'd3
    } rd_sel_t;

    // Register view reported with every item.
    typedef struct packed {
        logic [14:0] vram_address;
        logic [14:0] temp_address;
        logic [2:0]  fine_x_scroll;
        logic [7:0]  control_byte;
        logic [7:0]  mask_byte;
    } view_t;

    // Palette index with the four background mirrors folded down.
    function automatic logic [PALETTE_AW-1:0] pal_index(input logic [13:0] addr);
        logic [4:0] a;
        a = addr[4:0];
        if (a[4] && (a[1:0] == 2'b00))
        begin
            a[4] = 1'b0;
        end
        return a;
    endfunction

endpackage

FILE: hdl/pur_if.sv
// ----------------------------------------------------------------------------
// pur_if: item channels of the picture-unit register port
// pur_access_if carries CPU accesses in, pur_result_if carries results out.
// An item moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface pur_access_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [2:0] status_flags;

    modport source (output valid, output op, output reg_index, output write_data,
                    output status_flags, input ready);
    modport sink   (input valid, input op, input reg_index, input write_data,
                    input status_flags, output ready);
endinterface

interface pur_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [14:0] vram_address;
    logic [14:0] temp_address;
    logic [2:0]  fine_x_scroll;
    logic [7:0]  control_byte;
    logic [7:0]  mask_byte;

    modport source (output valid, output read_data, output vram_address,
                    output temp_address, output fine_x_scroll, output control_byte,
                    output mask_byte, input ready);
    modport sink   (input valid, input read_data, input vram_address,
                    input temp_address, input fine_x_scroll, input control_byte,
                    input mask_byte, output ready);
endinterface

FILE: hdl/pur_ram.sv
// ----------------------------------------------------------------------------
// pur_ram: synchronous byte memory with one write port and one read port
// One write and one read per cycle; the read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module pur_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/picture_unit_register_port_unit.sv
// ----------------------------------------------------------------------------
// picture_unit_register_port_unit: CPU-side registers of a picture unit
// Control, mask, status, sprite and scroll registers, the shared two-write
// toggle, and the buffered video data port over pattern, nametable and
// palette memories.
//
//   Channel  | Dir | Handshake      | Payload
//   ---------+-----+----------------+------------------------------------------
//   access   | in  | valid / ready  | op, reg_index, write_data, status_flags
//   result   | out | valid / ready  | read_data, vram_address, temp_address,
//            |     |                | fine_x_scroll, control_byte, mask_byte
//   cfg      | in  | cfg_we         | cfg_wdata (mirroring mode)
//
// One item per cycle is accepted while the result side keeps up; its result
// passes the first stage, with the memory read, and then the output register.
// Registers update at acceptance; memory data for the read buffer is
// forwarded from the memory output until it is committed the cycle after.
// A stall on the result side holds both stages and drops access.ready once
// both are full. Reset clears state and valid flags, not stage data or memory.
// ----------------------------------------------------------------------------
module picture_unit_register_port_unit #(
    parameter int NAMETABLE_BYTES = 2048
) (
    input  logic       clk,
    input  logic       rst_n,
    pur_access_if.sink access,
    pur_result_if.source result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);

    import pur_pkg::*;

    localparam int NT_AW = $clog2(NAMETABLE_BYTES);

    // Architectural registers.
    logic [1:0]  mirroring_reg;
    logic [7:0]  control_reg,  control_next;
    logic [7:0]  mask_reg,     mask_next;
    logic [2:0]  status_reg,   status_next;
    logic [14:0] cur_addr_reg, cur_addr_next;
    logic [14:0] tmp_addr_reg, tmp_addr_next;
    logic [2:0]  fine_x_reg,   fine_x_next;
    logic        toggle_reg,   toggle_next;
    logic [7:0]  sp_addr_reg,  sp_addr_next;
    logic [7:0]  read_buffer_reg;
    logic        buf_pend_reg, buf_pend_next;
    bus_src_t    bus_src_reg,  bus_src_next;

    // Pipeline registers.
    logic        s1_valid_reg;
    rd_sel_t     s1_rd_sel_reg, s1_rd_sel_next;
    logic [7:0]  s1_rd_value_reg, s1_rd_value_next;
    view_t       s1_view_reg;
    logic        out_valid_reg;
    logic [7:0]  out_rd_reg;
    view_t       out_view_reg;

    // Memory ports.
    logic                  sp_we, sp_re;
    logic [7:0]            sp_rdata;
    logic                  pat_we, pat_re;
    logic [7:0]            pat_rdata;
    logic                  nt_we, nt_re;
    logic [7:0]            nt_rdata;
    logic                  pal_we, pal_re;
    logic [7:0]            pal_rdata;
    logic [NT_IDX_W-1:0]   nt_idx;
    logic [PALETTE_AW-1:0] pal_idx;

    logic        accept;
    logic        s1_advance;
    logic [13:0] bus_addr;
    logic [14:0] addr_step;
    logic [7:0]  bus_data;
    logic [7:0]  buf_eff;
    logic        is_pattern, is_palette, nt_on;
    logic [7:0]  rd_final;

    // Handshake: the first stage moves when the output register is free or taken.
    assign s1_advance   = !out_valid_reg || result.ready;
    assign access.ready = !s1_valid_reg || s1_advance;
    assign accept       = access.valid && access.ready;

    // Video bus decode of the current address.
    assign bus_addr   = cur_addr_reg[13:0];
    assign is_pattern = !bus_addr[13];
    assign is_palette = (bus_addr[13:8] == PALETTE_PAGE);
    assign nt_on      = (mirroring_reg == MIRROR_VERTICAL)
                     || (mirroring_reg == MIRROR_HORIZONTAL);
    assign nt_idx     = (mirroring_reg == MIRROR_VERTICAL) ? bus_addr[10:0]
                                                           : {bus_addr[11], bus_addr[9:0]};
    assign pal_idx    = pal_index(bus_addr);
    assign addr_step  = cur_addr_reg + (control_reg[2] ? 15'd32 : 15'd1);

    // Data from the latest video read, and the read buffer with it forwarded.
    always_comb
    begin
        case (bus_src_reg)
            SRC_PATTERN:   bus_data = pat_rdata;
            SRC_NAMETABLE: bus_data = nt_rdata;
            SRC_PALETTE:   bus_data = pal_rdata;
            default:       bus_data = 8'd0;
        endcase
    end

    assign buf_eff = buf_pend_reg ? bus_data : read_buffer_reg;

    // Register updates and memory requests for an accepted item.
    always_comb
    begin
        control_next     = control_reg;
        mask_next        = mask_reg;
        status_next      = status_reg;
        cur_addr_next    = cur_addr_reg;
        tmp_addr_next    = tmp_addr_reg;
        fine_x_next      = fine_x_reg;
        toggle_next      = toggle_reg;
        sp_addr_next     = sp_addr_reg;
        buf_pend_next    = 1'b0;
        bus_src_next     = bus_src_reg;
        s1_rd_sel_next   = RD_VALUE;
        s1_rd_value_next = 8'd0;
        sp_we  = 1'b0;
        sp_re  = 1'b0;
        pat_we = 1'b0;
        pat_re = 1'b0;
        nt_we  = 1'b0;
        nt_re  = 1'b0;
        pal_we = 1'b0;
        pal_re = 1'b0;

        if (accept)
        begin
            case (op_t'(access.op))
                OP_READ:
                begin
                    case (access.reg_index)
                        REG_STATUS:
                        begin
                            s1_rd_value_next = {status_reg, buf_eff[4:0]};
                            status_next[2]   = 1'b0;
                            toggle_next      = 1'b0;
                        end
                        REG_SPDATA:
                        begin
                            sp_re          = 1'b1;
                            s1_rd_sel_next = RD_SPRITE;
                        end
                        REG_DATA:
                        begin
                            // The old buffer is returned except for palette reads.
                            s1_rd_value_next = buf_eff;
                            s1_rd_sel_next   = is_palette ? RD_BUS : RD_VALUE;
                            buf_pend_next    = 1'b1;
                            if (is_pattern)
                            begin
                                pat_re       = 1'b1;
                                bus_src_next = SRC_PATTERN;
                            end
                            else if (is_palette)
                            begin
                                pal_re       = 1'b1;
                                bus_src_next = SRC_PALETTE;
                            end
                            else if (nt_on)
                            begin
                                nt_re        = 1'b1;
                                bus_src_next = SRC_NAMETABLE;
                            end
                            else
                            begin
                                bus_src_next = SRC_ZERO;
                            end
                            cur_addr_next = addr_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_WRITE:
                begin
                    case (access.reg_index)
                        REG_CTRL:
                        begin
                            control_next         = access.write_data;
                            tmp_addr_next[11:10] = access.write_data[1:0];
                        end
                        REG_MASK:
                        begin
                            mask_next = access.write_data;
                        end
                        REG_SPADDR:
                        begin
                            sp_addr_next = access.write_data;
                        end
                        REG_SPDATA:
                        begin
                            sp_we        = 1'b1;
                            sp_addr_next = sp_addr_reg + 8'd1;
                        end
                        REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                fine_x_next        = access.write_data[2:0];
                                tmp_addr_next[4:0] = access.write_data[7:3];
                            end
                            else
                            begin
                                tmp_addr_next[14:12] = access.write_data[2:0];
                                tmp_addr_next[9:5]   = access.write_data[7:3];
                            end
                            toggle_next = !toggle_reg;
                        end
                        REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                tmp_addr_next[14]   = 1'b0;
                                tmp_addr_next[13:8] = access.write_data[5:0];
                            end
                            else
                            begin
                                tmp_addr_next[7:0] = access.write_data;
                                cur_addr_next      = {tmp_addr_reg[14:8], access.write_data};
                            end
                            toggle_next = !toggle_reg;
                        end
                        REG_DATA:
                        begin
                            if (is_pattern)
                            begin
                                pat_we = 1'b1;
                            end
                            else if (is_palette)
                            begin
                                pal_we = 1'b1;
                            end
                            else
                            begin
                                nt_we = nt_on;
                            end
                            cur_addr_next = addr_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_STATUS:
                begin
                    status_next = access.status_flags;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Architectural state, including the read buffer commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirroring_reg   <= 2'd0;
            control_reg     <= 8'd0;
            mask_reg        <= 8'd0;
            status_reg      <= 3'd0;
            cur_addr_reg    <= 15'd0;
            tmp_addr_reg    <= 15'd0;
            fine_x_reg      <= 3'd0;
            toggle_reg      <= 1'b0;
            sp_addr_reg     <= 8'd0;
            read_buffer_reg <= 8'd0;
            buf_pend_reg    <= 1'b0;
            bus_src_reg     <= SRC_ZERO;
        end
        else
        begin
            if (cfg_we)
            begin
                mirroring_reg <= cfg_wdata;
            end
            control_reg     <= control_next;
            mask_reg        <= mask_next;
            status_reg      <= status_next;
            cur_addr_reg    <= cur_addr_next;
            tmp_addr_reg    <= tmp_addr_next;
            fine_x_reg      <= fine_x_next;
            toggle_reg      <= toggle_next;
            sp_addr_reg     <= sp_addr_next;
            read_buffer_reg <= buf_eff;
            buf_pend_reg    <= buf_pend_next;
            bus_src_reg     <= bus_src_next;
        end
    end

    // First stage: the register view and the source of the read byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (access.ready)
        begin
            s1_valid_reg <= access.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_sel_reg   <= s1_rd_sel_next;
            s1_rd_value_reg <= s1_rd_value_next;
            s1_view_reg     <= '{vram_address:  cur_addr_next,
                                 temp_address:  tmp_addr_next,
                                 fine_x_scroll: fine_x_next,
                                 control_byte:  control_next,
                                 mask_byte:     mask_next};
        end
    end

    // Read byte once the memory data has arrived.
    always_comb
    begin
        case (s1_rd_sel_reg)
            RD_SPRITE: rd_final = sp_rdata;
            RD_BUS:    rd_final = bus_data;
            default:   rd_final = s1_rd_value_reg;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_rd_reg   <= rd_final;
            out_view_reg <= s1_view_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.read_data     = out_rd_reg;
    assign result.vram_address  = out_view_reg.vram_address;
    assign result.temp_address  = out_view_reg.temp_address;
    assign result.fine_x_scroll = out_view_reg.fine_x_scroll;
    assign result.control_byte  = out_view_reg.control_byte;
    assign result.mask_byte     = out_view_reg.mask_byte;

    // Video and sprite memories.
    pur_ram #(.DEPTH(SPRITE_BYTES), .WIDTH(8)) u_sprite_ram (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_addr_reg[SPRITE_AW-1:0]),
        .wdata (access.write_data),
        .re    (sp_re),
        .raddr (sp_addr_reg[SPRITE_AW-1:0]),
        .rdata (sp_rdata)
    );

    pur_ram #(.DEPTH(PATTERN_BYTES), .WIDTH(8)) u_pattern_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (bus_addr[PATTERN_AW-1:0]),
        .wdata (access.write_data),
        .re    (pat_re),
        .raddr (bus_addr[PATTERN_AW-1:0]),
        .rdata (pat_rdata)
    );

    pur_ram #(.DEPTH(NAMETABLE_BYTES), .WIDTH(8)) u_nametable_ram (
        .clk   (clk),
        .we    (nt_we),
        .waddr (NT_AW'(nt_idx)),
        .wdata (access.write_data),
        .re    (nt_re),
        .raddr (NT_AW'(nt_idx)),
        .rdata (nt_rdata)
    );

    pur_ram #(.DEPTH(PALETTE_ENTRIES), .WIDTH(8)) u_palette_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_idx),
        .wdata (access.write_data),
        .re    (pal_re),
        .raddr (pal_idx),
        .rdata (pal_rdata)
    );

endmodule
